[hdl/mbss_pkg.sv]
// Shared types and constants for the masked byte signature scanner.
package mbss_pkg;

	localparam int PATTERN_BYTES = 16;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int LEN_W         = 5;
	localparam int ALIGN_W       = 3;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_PTR_W   = 2;
	localparam int QUEUE_CNT_W   = 3;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LO = 3'd0,
		CFG_PATTERN_HI = 3'd1,
		CFG_MASK_LO    = 3'd2,
		CFG_MASK_HI    = 3'd3,
		CFG_LENGTH     = 3'd4,
		CFG_ALIGN      = 3'd5,
		CFG_FIRST_ONLY = 3'd6,
		CFG_REVERSE    = 3'd7
	} cfg_index_t;

	// Scan settings handed from the register file to the front end
	typedef struct packed {
		logic [PATTERN_BYTES-1:0][7:0] pattern;
		logic [PATTERN_BYTES-1:0][7:0] mask;
		logic [LEN_W-1:0]              pattern_length;
		logic [ALIGN_W-1:0]            align_log2;
		logic                          first_only;
		logic                          reverse_dir;
	} scan_cfg_t;

endpackage

[hdl/mbss_front.sv]
// Front end: byte window, masked compare and match selection per word.
module mbss_front #(
	parameter int PATTERN_MAX = 16,
	parameter int ADDR_WIDTH  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mbss_pkg::scan_cfg_t   cfg,
	input  logic                  take,
	input  logic [7:0]            mem_byte,
	input  logic [ADDR_WIDTH-1:0] byte_addr,
	input  logic                  last_byte,
	output logic                  emit,
	output logic                  found,
	output logic [ADDR_WIDTH-1:0] match_addr,
	output logic                  end_of_scan
);
	import mbss_pkg::*;

	localparam int FILL_W = $clog2(PATTERN_MAX + 1);

	logic [7:0]            win_q [PATTERN_MAX];
	logic [7:0]            win_next [PATTERN_MAX];
	logic [FILL_W-1:0]     fill_q;
	logic [FILL_W-1:0]     fill_next;
	logic                  finished_q;
	logic                  held_valid_q;
	logic [ADDR_WIDTH-1:0] held_addr_q;
	logic [FILL_W-1:0]     len_eff;
	logic [ADDR_WIDTH-1:0] start_addr;
	logic [ADDR_WIDTH-1:0] align_mask;
	logic [PATTERN_MAX-1:0] byte_ok;
	logic                  aligned;
	logic                  match;
	logic                  have;
	logic [ADDR_WIDTH-1:0] res_addr;

	// Shift the incoming byte into the window
	always_comb begin
		win_next[0] = mem_byte;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_next[k] = win_q[k-1];
		end
	end

	// Clamp the pattern length to between one byte and the window size
	always_comb begin
		if (cfg.pattern_length == '0) begin
			len_eff = FILL_W'(1);
		end else if (int'(cfg.pattern_length) > PATTERN_MAX) begin
			len_eff = FILL_W'(PATTERN_MAX);
		end else begin
			len_eff = FILL_W'(cfg.pattern_length);
		end
	end

	assign fill_next = (int'(fill_q) == PATTERN_MAX) ? fill_q : fill_q + FILL_W'(1);

	// Window start address and alignment test
	assign start_addr = byte_addr - ADDR_WIDTH'(len_eff - FILL_W'(1));

	always_comb begin
		for (int b = 0; b < ADDR_WIDTH; b++) begin
			align_mask[b] = (b < int'(cfg.align_log2));
		end
	end

	assign aligned = ((start_addr & align_mask) == '0);

	// Masked compare: the byte k steps back meets pattern byte len-1-k
	always_comb begin
		logic [3:0] pidx;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			pidx = 4'(int'(len_eff) - 1 - k);
			byte_ok[k] = (k >= int'(len_eff)) ||
				((win_next[k] & cfg.mask[pidx]) == (cfg.pattern[pidx] & cfg.mask[pidx]));
		end
	end

	assign match = (fill_next >= len_eff) && aligned && (&byte_ok);

	// Select the result for this word by mode
	always_comb begin
		have     = 1'b0;
		res_addr = start_addr;
		if (!cfg.first_only) begin
			have = match;
		end else if (!cfg.reverse_dir) begin
			have = match && !finished_q;
		end else begin
			have     = last_byte && (match || held_valid_q);
			res_addr = match ? start_addr : held_addr_q;
		end
	end

	assign emit        = take && (have || last_byte);
	assign found       = have;
	assign match_addr  = have ? res_addr : '0;
	assign end_of_scan = last_byte;

	// Advance the window on each accepted word and hold the latest match address
	always_ff @(posedge clk) begin
		if (take) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= win_next[k];
			end
			if (match) begin
				held_addr_q <= start_addr;
			end
		end
	end

	// Range state; drop it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			finished_q   <= 1'b0;
			held_valid_q <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				fill_q       <= '0;
				finished_q   <= 1'b0;
				held_valid_q <= 1'b0;
			end else begin
				fill_q <= fill_next;
				if (cfg.first_only && !cfg.reverse_dir && match) begin
					finished_q <= 1'b1;
				end
				// Only reverse first-only mode holds a match for the range end
				if (cfg.first_only && cfg.reverse_dir && match) begin
					held_valid_q <= 1'b1;
				end
			end
		end
	end

endmodule

[hdl/mbss_queue.sv]
// Back end: short result queue whose head drives the output channel.
module mbss_queue #(
	parameter int DATA_W = 34
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output logic [DATA_W-1:0] head_data
);
	import mbss_pkg::*;

	logic [DATA_W-1:0]      slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full       = (int'(count_q) == QUEUE_DEPTH);
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rd_ptr_q];

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

[hdl/masked_byte_signature_scan.sv]
// Top level of the masked byte signature scanner: registers, front end and result queue.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid/in_ready, mem_byte,          | into block
//           | byte_addr, last_byte                  |
//   out     | out_valid/out_ready, found,           | out of block
//           | match_addr, end_of_scan               |
//   cfg     | cfg_we, cfg_index, cfg_data           | into block
//
// One byte word is taken every cycle while the queue has room; its result, if any, is
// registered into a four-entry queue whose head is offered on the output.
// The input stalls only while that queue is full.
// Reset loads the register reset values and empties the queue and range state.
module masked_byte_signature_scan #(
	parameter int PATTERN_MAX = 16,
	parameter int ADDR_WIDTH  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mbss_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mbss_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       mem_byte,
	input  logic [ADDR_WIDTH-1:0]            byte_addr,
	input  logic                             last_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             found,
	output logic [ADDR_WIDTH-1:0]            match_addr,
	output logic                             end_of_scan
);
	import mbss_pkg::*;

	localparam int RES_W = ADDR_WIDTH + 2;

	logic [CFG_DATA_W-1:0] pat_lo_q;
	logic [CFG_DATA_W-1:0] pat_hi_q;
	logic [CFG_DATA_W-1:0] mask_lo_q;
	logic [CFG_DATA_W-1:0] mask_hi_q;
	logic [LEN_W-1:0]      length_q;
	logic [ALIGN_W-1:0]    align_q;
	logic                  first_only_q;
	logic                  reverse_q;
	scan_cfg_t             scan_cfg;

	logic                  take;
	logic                  emit;
	logic                  fe_found;
	logic [ADDR_WIDTH-1:0] fe_addr;
	logic                  fe_eos;
	logic                  q_full;
	logic [RES_W-1:0]      head;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q     <= '0;
			pat_hi_q     <= '0;
			mask_lo_q    <= '1;
			mask_hi_q    <= '1;
			length_q     <= LEN_W'(1);
			align_q      <= '0;
			first_only_q <= 1'b0;
			reverse_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_PATTERN_LO: pat_lo_q     <= cfg_data;
				CFG_PATTERN_HI: pat_hi_q     <= cfg_data;
				CFG_MASK_LO:    mask_lo_q    <= cfg_data;
				CFG_MASK_HI:    mask_hi_q    <= cfg_data;
				CFG_LENGTH:     length_q     <= cfg_data[LEN_W-1:0];
				CFG_ALIGN:      align_q      <= cfg_data[ALIGN_W-1:0];
				CFG_FIRST_ONLY: first_only_q <= cfg_data[0];
				CFG_REVERSE:    reverse_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign scan_cfg.pattern        = {pat_hi_q, pat_lo_q};
	assign scan_cfg.mask           = {mask_hi_q, mask_lo_q};
	assign scan_cfg.pattern_length = length_q;
	assign scan_cfg.align_log2     = align_q;
	assign scan_cfg.first_only     = first_only_q;
	assign scan_cfg.reverse_dir    = reverse_q;

	// Accept a word whenever the queue has room
	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	mbss_front #(
		.PATTERN_MAX (PATTERN_MAX),
		.ADDR_WIDTH  (ADDR_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (scan_cfg),
		.take        (take),
		.mem_byte    (mem_byte),
		.byte_addr   (byte_addr),
		.last_byte   (last_byte),
		.emit        (emit),
		.found       (fe_found),
		.match_addr  (fe_addr),
		.end_of_scan (fe_eos)
	);

	mbss_queue #(
		.DATA_W (RES_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (emit),
		.push_data  ({fe_found, fe_eos, fe_addr}),
		.full       (q_full),
		.pop        (out_valid && out_ready),
		.head_valid (out_valid),
		.head_data  (head)
	);

	assign found       = head[RES_W-1];
	assign end_of_scan = head[RES_W-2];
	assign match_addr  = head[ADDR_WIDTH-1:0];

endmodule

[sim/tb_top.sv]
// Testbench for the masked byte signature scanner: predicting scoreboard, drivers and checks.

typedef struct packed {
	logic        found;
	logic [31:0] addr;
	logic        eos;
} scan_report_t;

// Predict scan results from accepted byte words and check the block's reports
class scan_checker;
	logic [15:0][7:0] pattern_r;
	logic [15:0][7:0] mask_r;
	logic [4:0]       length_r;
	logic [2:0]       align_r;
	bit               first_only_r;
	bit               reverse_r;

	logic [7:0]  recent [16];
	int unsigned fill;
	bit          fwd_done;
	logic [31:0] held_addr;
	bit          held_ok;

	scan_report_t expected_reports [$];
	int failures;
	int words_seen;
	int found_reports;
	int end_reports;

	function new();
		pattern_r    = '0;
		mask_r       = '1;
		length_r     = 5'd1;
		align_r      = 3'd0;
		first_only_r = 1'b0;
		reverse_r    = 1'b0;
		failures     = 0;
		words_seen   = 0;
		found_reports = 0;
		end_reports  = 0;
		clear_range();
	endfunction

	function void clear_range();
		foreach (recent[k])
			recent[k] = 8'h00;
		fill      = 0;
		fwd_done  = 1'b0;
		held_addr = '0;
		held_ok   = 1'b0;
	endfunction

	// Zero counts as one byte, anything past sixteen saturates
	function int unsigned eff_len();
		if (length_r == 0)
			return 1;
		if (length_r > 16)
			return 16;
		return length_r;
	endfunction

	function void write_reg(mbss_pkg::cfg_index_t idx, logic [63:0] v);
		case (idx)
			mbss_pkg::CFG_PATTERN_LO: pattern_r[7:0]  = v;
			mbss_pkg::CFG_PATTERN_HI: pattern_r[15:8] = v;
			mbss_pkg::CFG_MASK_LO:    mask_r[7:0]     = v;
			mbss_pkg::CFG_MASK_HI:    mask_r[15:8]    = v;
			mbss_pkg::CFG_LENGTH:     length_r        = v[4:0];
			mbss_pkg::CFG_ALIGN:      align_r         = v[2:0];
			mbss_pkg::CFG_FIRST_ONLY: first_only_r    = v[0];
			mbss_pkg::CFG_REVERSE:    reverse_r       = v[0];
			default: ;
		endcase
	endfunction

	function void complain(string msg);
		failures++;
		if (failures <= 10)
			$display("ERROR: %s", msg);
	endfunction

	// Advance the window by one accepted word and queue the report it causes
	function void note_word(logic [7:0] b, logic [31:0] a, logic l);
		int unsigned  n;
		logic [31:0]  start;
		logic [31:0]  amask;
		bit           hit;
		bit           have;
		logic [31:0]  res;
		scan_report_t rep;

		n = eff_len();
		for (int k = 15; k > 0; k--)
			recent[k] = recent[k-1];
		recent[0] = b;
		if (fill < 16)
			fill++;

		hit   = 1'b0;
		start = '0;
		if (fill >= n) begin
			start = a - 32'(n - 1);
			amask = (32'd1 << align_r) - 32'd1;
			if ((start & amask) == 0) begin
				hit = 1'b1;
				for (int i = 0; i < n; i++) begin
					if ((recent[n-1-i] & mask_r[i]) != (pattern_r[i] & mask_r[i]))
						hit = 1'b0;
				end
			end
		end

		have = 1'b0;
		res  = '0;
		if (!first_only_r) begin
			if (hit) begin
				have = 1'b1;
				res  = start;
			end
		end else if (!reverse_r) begin
			if (hit && !fwd_done) begin
				fwd_done = 1'b1;
				have     = 1'b1;
				res      = start;
			end
		end else begin
			if (hit) begin
				held_addr = start;
				held_ok   = 1'b1;
			end
			if (l && held_ok) begin
				have = 1'b1;
				res  = held_addr;
			end
		end

		if (have || l) begin
			rep.found = have;
			rep.addr  = have ? res : 32'd0;
			rep.eos   = l;
			expected_reports.insert(expected_reports.size(), rep);
			if (have)
				found_reports++;
			if (l)
				end_reports++;
		end
		if (l)
			clear_range();
		words_seen++;
	endfunction

	// Compare one accepted report with the oldest prediction
	function void check_report(logic f, logic [31:0] a, logic e);
		scan_report_t want;
		scan_report_t got;

		got.found = f;
		got.addr  = a;
		got.eos   = e;
		if (expected_reports.size() == 0) begin
			complain($sformatf("unexpected report found=%0b addr=%h end=%0b", f, a, e));
		end else begin
			want = expected_reports.pop_front();
			if (want !== got)
				complain($sformatf({"report mismatch: expected found=%0b addr=%h end=%0b,",
					" got found=%0b addr=%h end=%0b"},
					want.found, want.addr, want.eos, got.found, got.addr, got.eos));
		end
	endfunction
endclass

module tb_top;
	import mbss_pkg::*;

	localparam int RANDOM_WORDS   = 1300;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	cfg_index_t  cfg_index = CFG_PATTERN_LO;
	logic [63:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  mem_byte  = '0;
	logic [31:0] byte_addr = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	logic [31:0] match_addr;
	logic        end_of_scan;

	scan_checker sb = new();

	logic [63:0] cfg_vals [8] = '{64'h0, 64'h0, {64{1'b1}}, {64{1'b1}}, 64'd1, 64'd0,
		64'd0, 64'd0};

	bit       gaps_on;
	int       burst_left;
	int       ranges_sent;
	int       phases;
	int       quiet;
	rx_mode_t rx_mode;
	int       rx_left;
	int       rx_tick;

	masked_byte_signature_scan u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mem_byte    (mem_byte),
		.byte_addr   (byte_addr),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.match_addr  (match_addr),
		.end_of_scan (end_of_scan)
	);

	always #6 clk = ~clk;

	// Note accepted words first, then check reports taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_word(mem_byte, byte_addr, last_byte);
			if (out_valid && out_ready)
				sb.check_report(found, match_addr, end_of_scan);
		end
	end

	// Stall the receiver on a changing pattern of its own
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 200);
			rx_tick = 0;
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_ALWAYS: out_ready <= 1'b1;
			RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 7);
			RX_SPARSE: out_ready <= (rx_tick % 6 == 0);
			default:   out_ready <= (rx_tick % 40 >= 30);
		endcase
	end

	// End the run when no word moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", quiet);
			$display("Some tests failed");
			$finish;
		end
	end

	// Offer one byte word, idling between bursts, and hold it until taken
	task automatic push_byte(input logic [7:0] b, input logic [31:0] a, input logic l);
		if (burst_left == 0) begin
			if (gaps_on) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		in_valid  <= 1'b1;
		mem_byte  <= b;
		byte_addr <= a;
		last_byte <= l;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Drop valid, let the last word be noted, and hold until every report has come back
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings();
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_index_t'(i);
			cfg_data  <= cfg_vals[i];
			@(posedge clk);
			sb.write_reg(cfg_index_t'(i), cfg_vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] rand_mask64();
		logic [63:0] m;

		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, 9))
				0, 1:    m[8*i +: 8] = 8'h00;
				2, 3, 4: m[8*i +: 8] = 8'($urandom);
				default: m[8*i +: 8] = 8'hFF;
			endcase
		end
		return m;
	endfunction

	// Fill unused upper bits of a narrow register with noise half the time
	function automatic logic [63:0] with_noise(logic [63:0] v, int w);
		logic [63:0] keep;

		keep = (64'd1 << w) - 64'd1;
		if ($urandom_range(0, 1))
			return ({$urandom, $urandom} & ~keep) | (v & keep);
		return v & keep;
	endfunction

	// Send one range, planting whole or broken pattern copies at aligned starts
	task automatic send_range(input logic [31:0] base, input int n, input int plants);
		logic [7:0]  range_data [256];
		int unsigned len;
		int unsigned step;
		int unsigned off0;
		int unsigned slots;
		int unsigned p;
		int unsigned k;

		for (int j = 0; j < n; j++)
			range_data[j] = 8'($urandom);
		len  = sb.eff_len();
		step = 1 << sb.align_r;
		off0 = (step - (base % step)) % step;
		repeat (plants) begin
			if (off0 + len <= n) begin
				slots = (n - len - off0) / step + 1;
				p = off0 + step * $urandom_range(0, slots - 1);
				for (int i = 0; i < len; i++)
					range_data[p+i] = (sb.pattern_r[i] & sb.mask_r[i]) |
						(8'($urandom) & ~sb.mask_r[i]);
				if ($urandom_range(0, 3) == 0) begin
					k = $urandom_range(0, len - 1);
					range_data[p+k] ^= sb.mask_r[k];
				end
			end
		end
		for (int j = 0; j < n; j++)
			push_byte(range_data[j], base + 32'(j), j == n - 1);
		ranges_sent++;
	endtask

	initial begin
		int          n;
		int unsigned len;
		logic [31:0] base;
		logic [31:0] amask;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero byte matches, range crossing the address wrap
		gaps_on = 1'b0;
		push_byte(8'h00, 32'hFFFF_FFFE, 1'b0);
		push_byte(8'hFF, 32'hFFFF_FFFF, 1'b0);
		push_byte(8'h00, 32'h0000_0000, 1'b1);
		push_byte(8'hFF, 32'h7FFF_FFFF, 1'b1);
		push_byte(8'h00, 32'h8000_0000, 1'b1);
		ranges_sent += 3;
		wait_drain();

		// Zero length acts as one byte; reverse first-only holds the highest match
		cfg_vals[CFG_PATTERN_LO] = 64'hAA;
		cfg_vals[CFG_LENGTH]     = 64'd0;
		cfg_vals[CFG_FIRST_ONLY] = 64'd1;
		cfg_vals[CFG_REVERSE]    = 64'd1;
		apply_settings();
		push_byte(8'hAA, 32'h0000_0200, 1'b0);
		push_byte(8'h11, 32'h0000_0201, 1'b0);
		push_byte(8'hAA, 32'h0000_0202, 1'b0);
		push_byte(8'h22, 32'h0000_0203, 1'b1);
		ranges_sent++;
		wait_drain();

		// Oversized length saturates; forward first match lands on the final byte
		cfg_vals[CFG_PATTERN_LO] = {$urandom, $urandom};
		cfg_vals[CFG_PATTERN_HI] = {$urandom, $urandom};
		cfg_vals[CFG_MASK_LO]    = 64'd0;
		cfg_vals[CFG_MASK_HI]    = 64'd0;
		cfg_vals[CFG_LENGTH]     = 64'd20;
		cfg_vals[CFG_ALIGN]      = 64'd4;
		cfg_vals[CFG_REVERSE]    = 64'd0;
		apply_settings();
		send_range(32'h0000_1000, 16, 0);
		wait_drain();

		// Random phases: new settings, a few ranges, then drain before the next write
		while (sb.words_seen < RANDOM_WORDS + 25) begin
			if (phases == 0) begin
				cfg_vals[CFG_PATTERN_LO] = '1;
				cfg_vals[CFG_PATTERN_HI] = '1;
				cfg_vals[CFG_MASK_LO]    = '1;
				cfg_vals[CFG_MASK_HI]    = '1;
				cfg_vals[CFG_LENGTH]     = 64'd16;
				cfg_vals[CFG_ALIGN]      = 64'd0;
				cfg_vals[CFG_FIRST_ONLY] = 64'd0;
				cfg_vals[CFG_REVERSE]    = 64'd0;
			end else if (phases == 1) begin
				cfg_vals[CFG_PATTERN_LO] = '0;
				cfg_vals[CFG_PATTERN_HI] = '0;
				cfg_vals[CFG_MASK_LO]    = rand_mask64();
				cfg_vals[CFG_MASK_HI]    = rand_mask64();
				cfg_vals[CFG_LENGTH]     = 64'd31;
				cfg_vals[CFG_ALIGN]      = 64'd7;
				cfg_vals[CFG_FIRST_ONLY] = 64'd1;
				cfg_vals[CFG_REVERSE]    = 64'd1;
			end else begin
				cfg_vals[CFG_PATTERN_LO] = {$urandom, $urandom};
				cfg_vals[CFG_PATTERN_HI] = {$urandom, $urandom};
				cfg_vals[CFG_MASK_LO]    = rand_mask64();
				cfg_vals[CFG_MASK_HI]    = rand_mask64();
				case ($urandom_range(0, 19))
					0, 1:    len = 0;
					2, 3:    len = $urandom_range(17, 31);
					4, 5, 6: len = 16;
					7, 8, 9: len = 1;
					default: len = $urandom_range(2, 15);
				endcase
				cfg_vals[CFG_LENGTH]     = with_noise(64'(len), 5);
				case ($urandom_range(0, 9))
					0, 1, 2, 3: cfg_vals[CFG_ALIGN] = with_noise(64'd0, 3);
					4:          cfg_vals[CFG_ALIGN] = with_noise(64'($urandom_range(5, 7)), 3);
					default:    cfg_vals[CFG_ALIGN] = with_noise(64'($urandom_range(1, 4)), 3);
				endcase
				cfg_vals[CFG_FIRST_ONLY] = with_noise(64'($urandom_range(0, 1)), 1);
				cfg_vals[CFG_REVERSE]    = with_noise(64'($urandom_range(0, 1)), 1);
			end
			apply_settings();
			gaps_on = ($urandom_range(0, 3) != 0);
			amask   = (32'd1 << sb.align_r) - 32'd1;
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 19))
					0:       n = $urandom_range(121, 256);
					1, 2, 3: n = $urandom_range(49, 120);
					default: n = $urandom_range(1, 48);
				endcase
				case ($urandom_range(0, 19))
					0:       base = 32'hFFFF_FFFF - 32'($urandom_range(0, 60));
					1, 2, 3, 4, 5, 6, 7, 8, 9:
						base = $urandom & ~amask;
					default: base = $urandom;
				endcase
				send_range(base, n, $urandom_range(0, 3));
			end
			wait_drain();
			phases++;
		end

		repeat (10) @(posedge clk);
		if (sb.expected_reports.size() != 0)
			sb.complain($sformatf("%0d predicted reports never arrived",
				sb.expected_reports.size()));
		$display("Scanned %0d ranges, %0d byte words, over %0d random settings plus directed cases",
			ranges_sent, sb.words_seen, phases);
		$display("Predicted %0d match reports and %0d range ends; %0d failures",
			sb.found_reports, sb.end_reports, sb.failures);
		if (sb.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

[files.f]
hdl/mbss_pkg.sv
hdl/mbss_front.sv
hdl/mbss_queue.sv
hdl/masked_byte_signature_scan.sv
sim/tb_top.sv
